/* rtl/core/dmbb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// types, constants and state encoding for the direct-mapped block buffer cache
// used by the controller, the datapath and the top level; no dependencies

package dmbb_pkg;

   localparam int INDEX_BITS_DEF    = 5;
   localparam int BLOCK_W           = 31;
   localparam int SLOT_W            = 6;
   localparam int ROFF_W            = 4;
   localparam int ROOT_LIMIT        = 16;
   localparam int ROOT_CLOSE_OFFSET = 12;

   typedef enum logic {
      OP_ACCESS = 1'b0,
      OP_FLUSH  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic               opcode;
      logic [BLOCK_W-1:0] block_number;
      logic               mark_modified;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [ROFF_W-1:0]  root_offset;
      logic               hit;
      logic               write_back;
      logic [BLOCK_W-1:0] write_back_block;
      logic               fetch;
      logic [BLOCK_W-1:0] fetch_block;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_FLUSH,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic load;
      logic access;
      logic scan;
      logic final_root;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/dmbb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// controller state machine: sequences access lookups and flush walks
// depends on dmbb_pkg

module dmbb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 req_opcode,
   input  wire dmbb_pkg::status_type status,
   output logic                      busy,
   output dmbb_pkg::cmd_type         cmd
);

   dmbb_pkg::state_type state_ff;
   dmbb_pkg::state_type state_in;
   logic                accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmbb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmbb_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == dmbb_pkg::OP_FLUSH) begin
                  state_in = dmbb_pkg::ST_FLUSH;
               end else begin
                  state_in = dmbb_pkg::ST_ACCESS;
               end
            end
         end
         dmbb_pkg::ST_ACCESS: begin
            state_in = dmbb_pkg::ST_IDLE;
         end
         dmbb_pkg::ST_FLUSH: begin
            if (status.scan_last) begin
               state_in = dmbb_pkg::ST_FINAL;
            end
         end
         dmbb_pkg::ST_FINAL: begin
            state_in = dmbb_pkg::ST_IDLE;
         end
         default: begin
            state_in = dmbb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy           = 1'b1;
      cmd            = '0;
      unique case (state_ff)
         dmbb_pkg::ST_IDLE: begin
            busy     = reset;
            cmd.load = start;
         end
         dmbb_pkg::ST_ACCESS: begin
            cmd.access = 1'b1;
         end
         dmbb_pkg::ST_FLUSH: begin
            cmd.scan = 1'b1;
         end
         dmbb_pkg::ST_FINAL: begin
            cmd.final_root = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after transaction");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.access, cmd.scan, cmd.final_root}))
      else $error("more than one command active");

   a_flush_final: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && status.scan_last) |=> cmd.final_root)
      else $error("flush walk did not end in root write-back");

endmodule

`default_nettype wire

/* rtl/core/dmbb_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// datapath: tag memory, valid and dirty bits, scan pointer, result register
// depends on dmbb_pkg

module dmbb_dp #(
   parameter int INDEX_BITS = dmbb_pkg::INDEX_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dmbb_pkg::req_type    req_item,
   input  wire dmbb_pkg::cmd_type    cmd,
   output dmbb_pkg::status_type      status,
   output logic                      rsp_valid,
   output dmbb_pkg::rsp_type         rsp_item
);

   localparam int NSlots  = (1 << INDEX_BITS) + 1;
   localparam int NLines  = 1 << INDEX_BITS;
   localparam int PtrW    = $clog2(NSlots);
   localparam int SlotW   = dmbb_pkg::SLOT_W;
   localparam int RoffW   = dmbb_pkg::ROFF_W;
   localparam int BlockW  = dmbb_pkg::BLOCK_W;
   localparam int RootW   = $clog2(dmbb_pkg::ROOT_LIMIT);

   logic [BlockW-1:0]     tag_mem [NLines];
   logic [BlockW-1:0]     tag_rd_ff;
   logic [INDEX_BITS-1:0] rd_idx;

   dmbb_pkg::req_type     req_ff;
   logic [PtrW-1:0]       ptr_ff;
   logic [NSlots-1:0]     valid_ff;
   logic [NSlots-1:0]     valid_in;
   logic [NSlots-1:0]     dirty_ff;
   logic [NSlots-1:0]     dirty_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   dmbb_pkg::rsp_type     rsp_ff;
   dmbb_pkg::rsp_type     rsp_in;

   logic [BlockW-1:0]     blk;
   logic [INDEX_BITS-1:0] idx;
   logic [PtrW-1:0]       sidx;
   logic                  is_root;
   logic                  tag_hit;
   logic                  old_dirty;
   logic                  mem_wr;

   assign blk     = req_ff.block_number;
   assign idx     = blk[INDEX_BITS-1:0];
   assign sidx    = PtrW'(idx) + PtrW'(1);
   assign is_root = (blk[BlockW-1:RootW] == '0);
   assign tag_hit = valid_ff[sidx] && (tag_rd_ff == blk);
   assign old_dirty = valid_ff[sidx] && dirty_ff[sidx];
   assign mem_wr  = cmd.access && !is_root && !tag_hit;
   assign rd_idx  = cmd.scan ? ptr_ff[INDEX_BITS-1:0]
                             : req_item.block_number[INDEX_BITS-1:0];

   assign status.scan_last = (ptr_ff == PtrW'(NSlots - 1));

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         tag_mem[idx] <= blk;
      end
      tag_rd_ff <= tag_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            ptr_ff <= '0;
         end else if (cmd.scan) begin
            ptr_ff <= ptr_ff + PtrW'(1);
         end
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      if (cmd.access) begin
         rsp_valid_in = 1'b1;
         rsp_in.last  = 1'b1;
         if (is_root) begin
            rsp_in.root_offset = blk[RoffW-1:0];
            rsp_in.hit         = valid_ff[0];
            rsp_in.fetch       = !valid_ff[0];
            valid_in[0]        = 1'b1;
            dirty_in[0]        = 1'b1;
         end else begin
            rsp_in.slot = SlotW'(sidx);
            if (tag_hit) begin
               rsp_in.hit     = 1'b1;
               dirty_in[sidx] = dirty_ff[sidx] || req_ff.mark_modified;
            end else begin
               rsp_in.write_back       = old_dirty;
               rsp_in.write_back_block = old_dirty ? tag_rd_ff : '0;
               rsp_in.fetch            = 1'b1;
               rsp_in.fetch_block      = blk;
               valid_in[sidx]          = 1'b1;
               dirty_in[sidx]          = req_ff.mark_modified;
            end
         end
      end else if (cmd.scan) begin
         if (dirty_ff[ptr_ff]) begin
            rsp_valid_in            = 1'b1;
            rsp_in.slot             = SlotW'(ptr_ff);
            rsp_in.write_back       = 1'b1;
            rsp_in.write_back_block = (ptr_ff == '0) ? '0 : tag_rd_ff;
            dirty_in[ptr_ff]        = 1'b0;
         end
      end else if (cmd.final_root) begin
         rsp_valid_in       = 1'b1;
         rsp_in.root_offset = RoffW'(dmbb_pkg::ROOT_CLOSE_OFFSET);
         rsp_in.hit         = valid_ff[0];
         rsp_in.write_back  = 1'b1;
         rsp_in.fetch       = !valid_ff[0];
         rsp_in.last        = 1'b1;
         valid_in[0]        = 1'b1;
         dirty_in[0]        = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_access_result: assert property (@(posedge clock) disable iff (reset)
      cmd.access |=> (rsp_valid && rsp_item.last))
      else $error("access produced no final result");

   a_final_root: assert property (@(posedge clock) disable iff (reset)
      cmd.final_root |=> (valid_ff[0] && !dirty_ff[0] && rsp_valid && rsp_item.last))
      else $error("root not clean after flush");

   a_scan_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && dirty_ff[ptr_ff]) |=> (rsp_valid && rsp_item.write_back && !rsp_item.last))
      else $error("dirty slot skipped during flush");

endmodule

`default_nettype wire

/* rtl/core/direct_mapped_block_buffer_cache_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// top level of the direct-mapped write-back block buffer tag and dirty unit
// depends on dmbb_pkg, dmbb_ctrl and dmbb_dp
//
//   channel   ports                        handshake
//   request   start, busy, req_item        taken when start && !busy
//   response  rsp_valid, rsp_item          one cycle per result, no stall
//
// access: result registered in the cycle after the lookup cycle; next request taken back in ST_IDLE
// flush: walks all 2^INDEX_BITS+1 slots one per cycle, then the root write-back,
//   busy through ST_FLUSH and ST_FINAL after the request
// tag memory read is registered, so each lookup reads the tag in the cycle before the compare
// synchronous reset clears valid and dirty bits at once; tags need no clearing

module direct_mapped_block_buffer_cache_unit #(
   parameter int INDEX_BITS = dmbb_pkg::INDEX_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire dmbb_pkg::req_type req_item,
   output logic                   rsp_valid,
   output dmbb_pkg::rsp_type      rsp_item
);

   dmbb_pkg::cmd_type    cmd;
   dmbb_pkg::status_type status;

   dmbb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_item.opcode),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   dmbb_dp #(
      .INDEX_BITS (INDEX_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire
